### hw/rtl/assert_macros.svh
// Assertion shorthands for the click probability block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### hw/rtl/dcp_pkg.sv
package dcp_pkg;

  // probability format: unsigned Q1.31
  localparam int PROB_W = 32;
  localparam logic [PROB_W-1:0] PROB_ONE = 32'h8000_0000;

  localparam int MAX_DET_DEF = 64;

  // register file
  localparam int APB_AW = 4;
  localparam logic [1:0] REG_DET  = 2'd0;
  localparam logic [1:0] REG_EFF  = 2'd1;
  localparam logic [1:0] REG_DARK = 2'd2;

  // saturate a sum of two probabilities at 1.0
  function automatic logic [PROB_W-1:0] sat_one(input logic [PROB_W:0] s);
    return (s > {1'b0, PROB_ONE}) ? PROB_ONE : s[PROB_W-1:0];
  endfunction

  // clamp a register rate to 1.0
  function automatic logic [PROB_W-1:0] clamp_prob(input logic [PROB_W-1:0] v);
    return (v > PROB_ONE) ? PROB_ONE : v;
  endfunction

endpackage

### hw/rtl/dcp_div.sv
// Restoring divider, one quotient bit per cycle.
module dcp_div #(
  parameter int DEN_W = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dcp_pkg::PROB_W-1:0] num,
  input  logic [DEN_W-1:0]           den,
  output logic                       done,
  output logic [dcp_pkg::PROB_W-1:0] quo,
  output logic [DEN_W-1:0]           rem
);
  import dcp_pkg::*;

  localparam int CNT_W = $clog2(PROB_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [PROB_W-1:0] nreg;
  logic [DEN_W-1:0] dreg;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem, nreg[PROB_W-1]};
  assign diff  = trial - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PROB_W - 1);
        nreg <= num;
        dreg <= den;
        rem  <= '0;
      end else if (busy) begin
        nreg <= nreg << 1;
        if (trial >= {1'b0, dreg}) begin
          rem <= diff[DEN_W-1:0];
          quo <= {quo[PROB_W-2:0], 1'b1};
        end else begin
          rem <= trial[DEN_W-1:0];
          quo <= {quo[PROB_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/detector_click_probability.sv
// Click-count probability of a detector array. Each request (clicks L, photons N)
// returns P(L clicks | N photons) in unsigned Q1.31, saturated at 1.0; L above the
// detector count gives 0. One request is worked at a time. A request first divides
// eta by D, fills the eta*m/D table, then runs multiply-add updates: D*(D+3)/2
// updates for the dark-count row and, for each C = 0..min(L,N), sum over n of
// (min(C,n)+1) updates. Each update is paced by the one shared 32x32 multiplier
// and the single read port of each row memory. No clearing pass is needed after
// reset. Registers must be written over APB only while idle; the block itself
// does not enforce this.
`include "assert_macros.svh"

module detector_click_probability #(
  parameter int MAX_DET = dcp_pkg::MAX_DET_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,   // clicks[6:0], photons[13:7]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [dcp_pkg::PROB_W-1:0] m_tdata,   // probability[31:0]
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dcp_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import dcp_pkg::*;

  localparam int CW    = $clog2(MAX_DET + 1);
  localparam int WW    = (CW > 7) ? CW : 7;
  localparam int DEPTH = MAX_DET + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_FRAC, S_PINIT, S_PROW, S_UPD, S_CSTART, S_CLOAD,
    S_CZERO, S_NSTART, S_ACC, S_ACC2, S_FIN
  } state_t;

  // configuration registers
  logic [6:0]        det_count;
  logic [PROB_W-1:0] efficiency;
  logic [PROB_W-1:0] dark_prob;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_count  <= 7'd1;
      efficiency <= PROB_ONE;
      dark_prob  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_DET:  det_count  <= pwdata[6:0];
        REG_EFF:  efficiency <= pwdata;
        REG_DARK: dark_prob  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_DET:  prdata = {25'd0, det_count};
      REG_EFF:  prdata = efficiency;
      REG_DARK: prdata = dark_prob;
      default:  prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // request decode and clamping
  logic [WW-1:0]     dc_w, d_cl, l_in;
  logic [6:0]        n_in;
  logic [PROB_W-1:0] eta_cl, p_cl;

  assign dc_w   = WW'(det_count);
  assign d_cl   = (dc_w == '0) ? WW'(1) : ((dc_w > WW'(MAX_DET)) ? WW'(MAX_DET) : dc_w);
  assign l_in   = WW'(s_tdata[6:0]);
  assign n_in   = s_tdata[13:7];
  assign eta_cl = clamp_prob(efficiency);
  assign p_cl   = clamp_prob(dark_prob);

  state_t            state;
  logic [2:0]        step;
  logic              rec;
  logic [WW-1:0]     lq, d, i, d_i, cc, cmax;
  logic [6:0]        nq, n;
  logic [PROB_W-1:0] eta, p, q, fq, sum, t1;
  logic [WW:0]       fr;

  // eta / D
  logic              div_start, div_done;
  logic [PROB_W-1:0] q_eta;
  logic [CW-1:0]     r_eta;

  assign s_tready  = (state == S_IDLE);
  assign div_start = s_tvalid && s_tready && (l_in <= d_cl);

  dcp_div #(.DEN_W(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (eta_cl),
    .den   (d_cl[CW-1:0]),
    .done  (div_done),
    .quo   (q_eta),
    .rem   (r_eta)
  );

  // shared multiplier with rounding stage
  logic [PROB_W-1:0]   mul_a, mul_b, mq;
  logic [2*PROB_W-1:0] prod, rnd_sum;

  assign rnd_sum = prod + ((2*PROB_W)'(1) << (PROB_W - 2));

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    mq   <= rnd_sum[2*PROB_W-2:PROB_W-1];
  end

  // row memories: recurrence row, and {eta*m/D, dark-count row}
  logic [PROB_W-1:0]   mem_r [DEPTH];
  logic [2*PROB_W-1:0] mem_b [DEPTH];
  logic [PROB_W-1:0]   rd_r, wd;
  logic [2*PROB_W-1:0] rd_b;
  logic [CW-1:0]       ra_r, ra_b, wa;
  logic                we_r, we_lo, we_hi;

  always_ff @(posedge clk) begin
    if (we_r) begin
      mem_r[wa] <= wd;
    end
    rd_r <= mem_r[ra_r];
  end

  always_ff @(posedge clk) begin
    if (we_lo) begin
      mem_b[wa][PROB_W-1:0] <= wd;
    end
    if (we_hi) begin
      mem_b[wa][2*PROB_W-1:PROB_W] <= wd;
    end
    rd_b <= mem_b[ra_b];
  end

  // addressing
  logic [WW-1:0]     kk, im1, ki;
  logic [WW:0]       dk;
  logic              has2;
  logic [PROB_W:0]   a_rec;
  logic [PROB_W-1:0] a1, a2, m_rd, v;
  logic [WW:0]       fr_sum;

  assign kk     = lq - cc;
  assign has2   = (i != '0);
  assign im1    = has2 ? (i - 1'b1) : '0;
  assign ki     = kk + i;
  assign dk     = has2 ? ({1'b0, d} + 1'b1 - {1'b0, kk} - {1'b0, i}) : '0;
  assign a_rec  = {1'b0, PROB_ONE} - {1'b0, eta} + {1'b0, rd_b[2*PROB_W-1:PROB_W]};
  assign a1     = rec ? a_rec[PROB_W-1:0] : q;
  assign a2     = rec ? rd_b[2*PROB_W-1:PROB_W] : p;
  assign m_rd   = rec ? rd_r : rd_b[PROB_W-1:0];
  assign v      = sat_one({1'b0, t1} + {1'b0, mq});
  assign fr_sum = fr + (WW+1)'(r_eta);

  always_comb begin
    ra_r  = i[CW-1:0];
    ra_b  = i[CW-1:0];
    wa    = i[CW-1:0];
    wd    = '0;
    we_r  = 1'b0;
    we_lo = 1'b0;
    we_hi = 1'b0;
    case (state)
      S_FRAC: begin
        we_hi = 1'b1;
        wd    = fq;
      end
      S_PINIT: begin
        we_lo = 1'b1;
        wa    = '0;
        wd    = PROB_ONE;
      end
      S_PROW: begin
        we_lo = 1'b1;
        wa    = d_i[CW-1:0];
      end
      S_CSTART: ra_b = kk[CW-1:0];
      S_CLOAD: begin
        we_r = 1'b1;
        wa   = '0;
        wd   = rd_b[PROB_W-1:0];
      end
      S_CZERO: we_r = (i <= cc);
      S_ACC: ra_r = cc[CW-1:0];
      S_UPD: begin
        if (step == 3'd0) begin
          ra_b = rec ? ki[CW-1:0] : i[CW-1:0];
        end else if (step == 3'd1) begin
          ra_r = im1[CW-1:0];
          ra_b = rec ? dk[CW-1:0] : im1[CW-1:0];
        end else if (step == 3'd5) begin
          we_r  = rec;
          we_lo = !rec;
          wd    = v;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      sum      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // S_FIN drives the output handshake itself
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            lq   <= l_in;
            nq   <= n_in;
            d    <= d_cl;
            eta  <= eta_cl;
            p    <= p_cl;
            q    <= PROB_ONE - p_cl;
            sum  <= '0;
            cmax <= (l_in < WW'(n_in)) ? l_in : WW'(n_in);
            state <= (l_in > d_cl) ? S_FIN : S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            fq    <= '0;
            fr    <= (WW+1)'(d >> 1);
            i     <= '0;
            state <= S_FRAC;
          end
        end
        // eta*m/D rounded, stepped by quotient and remainder
        S_FRAC: begin
          if (fr_sum >= {1'b0, d}) begin
            fr <= fr_sum - {1'b0, d};
            fq <= fq + q_eta + 1'b1;
          end else begin
            fr <= fr_sum;
            fq <= fq + q_eta;
          end
          if (i == d) begin
            state <= S_PINIT;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_PINIT: begin
          d_i   <= WW'(1);
          state <= S_PROW;
        end
        S_PROW: begin
          i     <= d_i;
          step  <= '0;
          rec   <= 1'b0;
          state <= S_UPD;
        end
        // one multiply-add update of row entry i
        S_UPD: begin
          if (step == 3'd1) begin
            mul_a <= a1;
            mul_b <= m_rd;
          end
          if (step == 3'd2) begin
            mul_a <= has2 ? a2 : '0;
            mul_b <= m_rd;
          end
          if (step == 3'd4) begin
            t1 <= mq;
          end
          if (step == 3'd5) begin
            step <= '0;
            if (i != '0) begin
              i <= i - 1'b1;
            end else if (!rec) begin
              if (d_i == d) begin
                cc    <= '0;
                state <= S_CSTART;
              end else begin
                d_i   <= d_i + 1'b1;
                state <= S_PROW;
              end
            end else if (n == nq) begin
              state <= S_ACC;
            end else begin
              n     <= n + 1'b1;
              state <= S_NSTART;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_CSTART: state <= S_CLOAD;
        S_CLOAD: begin
          i     <= WW'(1);
          state <= S_CZERO;
        end
        S_CZERO: begin
          if (i <= cc) begin
            i <= i + 1'b1;
          end else if (nq == '0) begin
            state <= S_ACC;
          end else begin
            n     <= 7'd1;
            state <= S_NSTART;
          end
        end
        S_NSTART: begin
          i     <= (cc < WW'(n)) ? cc : WW'(n);
          step  <= '0;
          rec   <= 1'b1;
          state <= S_UPD;
        end
        S_ACC: state <= S_ACC2;
        S_ACC2: begin
          sum <= sat_one({1'b0, sum} + {1'b0, rd_r});
          if (cc == cmax) begin
            state <= S_FIN;
          end else begin
            cc    <= cc + 1'b1;
            state <= S_CSTART;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= sum;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `ASSERT_IMP(a_sum_range, clk, rst, 1'b1, sum <= PROB_ONE, "running sum above 1.0")
  `ASSERT_IMP(a_rec_index, clk, rst, state == S_UPD && rec && step == 3'd5, i <= cc, "recurrence write beyond current C")
  `ASSERT_IMP(a_div_done, clk, rst, div_done, state == S_DIV, "divider finished outside setup")
  `ASSERT_NXT(a_leave_idle, clk, rst, s_tvalid && s_tready, state != S_IDLE, "request accepted but sequencer idle")

endmodule

### test/tb.sv
module tb;
  import dcp_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [63:0] Q_ONE = 64'h8000_0000;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [15:0] s_tdata = '0;  // clicks[6:0], photons[13:7]
  logic m_tvalid;
  logic m_tready = 0;
  logic [PROB_W-1:0] m_tdata;  // probability[31:0]
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor copy of the register file
  logic [6:0] det_reg;
  logic [31:0] eff_reg, dark_reg;

  logic [PROB_W-1:0] prob_expected[$];
  int errors = 0;
  bit calm = 0;  // no idling on either side while set

  detector_click_probability DUT (.*);

  always #5 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'h4000_0000) >> 31;
  endfunction

  function automatic logic [63:0] qadd(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > Q_ONE) ? Q_ONE : s;
  endfunction

  function automatic logic [63:0] eta_frac(logic [63:0] eta, logic [63:0] m,
                                           logic [63:0] d);
    return (eta * m + d / 2) / d;
  endfunction

  function automatic logic [31:0] click_prob(int clk_cnt, int ph_cnt);
    logic [63:0] binom[0:64];
    logic [63:0] row[0:64];
    logic [63:0] eta, p, q, total, a, b, v, kk, dd;
    int dets, cmax, top;
    dets = det_reg;
    if (dets < 1) dets = 1;
    if (dets > 64) dets = 64;
    eta = (eff_reg > 32'h8000_0000) ? Q_ONE : {32'd0, eff_reg};
    p = (dark_reg > 32'h8000_0000) ? Q_ONE : {32'd0, dark_reg};
    q = Q_ONE - p;
    total = 0;
    dd = 64'(dets);
    if (clk_cnt <= dets) begin
      // dark-count binomial, one detector at a time
      binom[0] = Q_ONE;
      for (int d = 1; d <= dets; d++) begin
        binom[d] = 0;
        for (int k = d; k > 0; k--)
          binom[k] = qadd(qmul(q, binom[k]), qmul(p, binom[k-1]));
        binom[0] = qmul(q, binom[0]);
      end
      cmax = (clk_cnt < ph_cnt) ? clk_cnt : ph_cnt;
      for (int cc = 0; cc <= cmax; cc++) begin
        kk = 64'(clk_cnt - cc);
        row[0] = binom[kk[6:0]];
        for (int c = 1; c <= cc; c++) row[c] = 0;
        for (int n = 1; n <= ph_cnt; n++) begin
          top = (cc < n) ? cc : n;
          for (int c = top; c >= 0; c--) begin
            a = Q_ONE - eta + eta_frac(eta, kk + c, dd);
            v = qmul(a, row[c]);
            if (c > 0) begin
              b = eta_frac(eta, dd + 1 - kk - c, dd);
              v = qadd(v, qmul(b, row[c-1]));
            end
            row[c] = (v > Q_ONE) ? Q_ONE : v;
          end
        end
        total = qadd(total, row[cc]);
      end
    end
    return total[31:0];
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [PROB_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (prob_expected.size() == 0)
        report_mismatch($sformatf("unexpected result %h", m_tdata));
      else begin
        want = prob_expected.pop_front();
        if (m_tdata !== want)
          report_mismatch($sformatf("probability %h, want %h", m_tdata, want));
      end
    end
  end

  // ---------------- idling ----------------
  function automatic int gap_len();
    if (calm) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(2);
    return $urandom_range(40, 10);
  endfunction

  // receiver stalls
  initial begin
    int n;
    forever begin
      @(negedge clk);
      m_tready <= 1;
      n = $urandom_range(6);
      repeat (n) @(negedge clk);
      n = gap_len();
      if (n > 0) begin
        m_tready <= 0;
        repeat (n) @(negedge clk);
      end
    end
  end

  // ---------------- drivers ----------------
  task automatic send_query(int clk_cnt, int ph_cnt);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {2'b00, ph_cnt[6:0], clk_cnt[6:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    prob_expected.push_back(click_prob(clk_cnt[6:0], ph_cnt[6:0]));
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (prob_expected.size() != 0) @(posedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_DET: det_reg = val[6:0];
      REG_EFF: eff_reg = val;
      REG_DARK: dark_reg = val;
      default: ;
    endcase
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_array(logic [31:0] dets, logic [31:0] eta, logic [31:0] dark);
    apb_write(REG_DET, dets);
    apb_write(REG_EFF, eta);
    apb_write(REG_DARK, dark);
  endtask

  // ---------------- tests ----------------
  task automatic test_reset_values();
    send_query(0, 0);
    send_query(1, 1);
    send_query(0, 1);
    send_query(2, 0);
    drain();
  endtask

  task automatic test_extremes();
    // register index outside the map must not disturb anything
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    set_array(64, 32'h6000_0000, 32'h0100_0000);
    send_query(64, 1);
    send_query(1, 127);
    send_query(127, 5);
    send_query(63, 2);
    send_query(20, 18);
    drain();
    // zero detectors acts as one; rates above one clamp to one
    set_array(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_query(1, 3);
    send_query(0, 3);
    send_query(2, 1);
    drain();
    // detector count above the array limit clamps to the limit
    set_array(127, 32'h0, 32'h8000_0000);
    send_query(64, 0);
    send_query(65, 0);
    drain();
    set_array(5, 32'h8000_0000, 32'h0);
    send_query(5, 5);
    send_query(3, 7);
    send_query(6, 2);
    drain();
  endtask

  task automatic test_random_queries();
    int dets, cl, ph;
    logic [31:0] eta, dark;
    for (int phase = 0; phase < 6; phase++) begin
      calm = (phase == 2);
      dets = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(10, 1);
      case ($urandom_range(4))
        0: eta = 32'h8000_0000;
        1: eta = 32'h0;
        2: eta = $urandom;
        default: eta = $urandom_range(32'h8000_0000);
      endcase
      case ($urandom_range(4))
        0: dark = 32'h0;
        1: dark = 32'h8000_0000;
        2: dark = $urandom;
        default: dark = $urandom_range(32'h1000_0000);
      endcase
      set_array(dets, eta, dark);
      dets = det_reg;
      if (dets < 1) dets = 1;
      if (dets > 10) dets = 10;  // keep the recurrence short
      for (int i = 0; i < 17; i++) begin
        case ($urandom_range(9))
          0: begin
            cl = $urandom_range(127);
            ph = $urandom_range(127);
            if (cl <= 64) cl = $urandom_range(2);
          end
          1: begin
            cl = $urandom_range(2);
            ph = $urandom_range(127);
          end
          default: begin
            cl = $urandom_range(dets + 1);
            ph = $urandom_range(10);
          end
        endcase
        send_query(cl, ph);
      end
      drain();
    end
    calm = 0;
  endtask

  initial begin
    det_reg = 1;
    eff_reg = 32'h8000_0000;
    dark_reg = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_reset_values();
    test_extremes();
    test_random_queries();
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
